[rtl/owm_pkg.sv]
// owm_pkg: shared types and constants for the omni wheel mixer.
// No dependencies; every other rtl file imports this package.
package owm_pkg;

  localparam int PULSE_W     = 12;
  localparam int DB_W        = 9;
  localparam int DUTY_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;

  localparam int STICK_LIMIT    = 500;
  localparam int Q16_SHIFT      = 16;
  localparam int HALF_SHIFT     = 15;
  localparam int SQRT3_HALF_Q16 = 56756;
  localparam int DUTY_MAX       = 255;
  // floor(v / 5) == (v * 205) >> 10 for v below 1024
  localparam int RECIP5         = 205;
  localparam int RECIP5_SHIFT   = 10;

  localparam logic [PULSE_W-1:0] NEUTRAL_RST   = 12'd1500;
  localparam logic [DB_W-1:0]    STICK_DB_RST  = 9'd50;
  localparam logic [DB_W-1:0]    SPIN_DB_RST   = 9'd25;
  localparam logic [DUTY_W-1:0]  DUTY_BASE_RST = 8'd155;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEUTRAL   = 2'd0,
    REG_STICK_DB  = 2'd1,
    REG_SPIN_DB   = 2'd2,
    REG_DUTY_BASE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [PULSE_W-1:0] neutral_width;
    logic [DB_W-1:0]    stick_deadband;
    logic [DB_W-1:0]    spin_deadband;
    logic [DUTY_W-1:0]  duty_base;
  } cfg_t;

  // centred and clamped stick value, -500..500
  typedef logic signed [9:0]  stick_t;
  // wheel speed in Q16, |value| below 2^27
  typedef logic signed [27:0] speed_t;
  // whole speed units after capping, 0..500
  typedef logic [8:0]         units_t;

endpackage

[rtl/owm_ifs.sv]
// Handshake channels of the omni wheel mixer: command, result, config write.
// Depends on owm_pkg.
interface owm_cmd_if import owm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] x_pulse;
  logic [PULSE_W-1:0] y_pulse;
  logic [PULSE_W-1:0] spin_pulse;
  modport source (output valid, x_pulse, y_pulse, spin_pulse, input ready);
  modport sink   (input valid, x_pulse, y_pulse, spin_pulse, output ready);
endinterface

interface owm_mix_if import owm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              drive_on;
  logic              dir_a;
  logic              dir_b;
  logic              dir_c;
  logic [DUTY_W-1:0] duty_a;
  logic [DUTY_W-1:0] duty_b;
  logic [DUTY_W-1:0] duty_c;
  modport source (output valid, drive_on, dir_a, dir_b, dir_c, duty_a, duty_b, duty_c,
                  input ready);
  modport sink   (input valid, drive_on, dir_a, dir_b, dir_c, duty_a, duty_b, duty_c,
                  output ready);
endinterface

interface owm_cfg_if import owm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/owm_cfg_regs.sv]
// owm_cfg_regs: configuration register file of the mixer.
// Depends on owm_pkg and owm_ifs.
module owm_cfg_regs
  import owm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  owm_cfg_if.sink   cfg,
  output cfg_t      regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.neutral_width  <= NEUTRAL_RST;
      regs.stick_deadband <= STICK_DB_RST;
      regs.spin_deadband  <= SPIN_DB_RST;
      regs.duty_base      <= DUTY_BASE_RST;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_NEUTRAL:   regs.neutral_width  <= cfg.data;
        REG_STICK_DB:  regs.stick_deadband <= cfg.data[DB_W-1:0];
        REG_SPIN_DB:   regs.spin_deadband  <= cfg.data[DB_W-1:0];
        REG_DUTY_BASE: regs.duty_base      <= cfg.data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/owm_centre.sv]
// owm_centre: stage 1, centres and clamps the three sticks, deadband tests.
// Depends on owm_pkg.
module owm_centre
  import owm_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [PULSE_W-1:0] x_pulse,
  input  logic [PULSE_W-1:0] y_pulse,
  input  logic [PULSE_W-1:0] spin_pulse,
  input  cfg_t               regs,
  output stick_t             x,
  output stick_t             y,
  output stick_t             s,
  output logic               drive,
  output logic               spin_on
);

  localparam logic signed [12:0] LIM = 13'(STICK_LIMIT);

  function automatic stick_t centre_clamp(input logic [PULSE_W-1:0] p,
                                          input logic [PULSE_W-1:0] n);
    logic signed [12:0] v;
    v = $signed({1'b0, p}) - $signed({1'b0, n});
    if (v < -LIM)     return stick_t'(-LIM);
    else if (v > LIM) return stick_t'(LIM);
    else              return v[9:0];
  endfunction

  function automatic logic [DB_W-1:0] mag(input stick_t v);
    stick_t neg;
    neg = -v;
    return v[9] ? neg[DB_W-1:0] : v[DB_W-1:0];
  endfunction

  stick_t xc, yc, sc;
  logic   drive_c, spin_c;

  always_comb begin
    xc      = centre_clamp(x_pulse, regs.neutral_width);
    yc      = centre_clamp(y_pulse, regs.neutral_width);
    sc      = centre_clamp(spin_pulse, regs.neutral_width);
    drive_c = (mag(xc) > regs.stick_deadband) || (mag(yc) > regs.stick_deadband) ||
              (mag(sc) > regs.stick_deadband);
    spin_c  = mag(sc) > regs.spin_deadband;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x       <= xc;
      y       <= yc;
      s       <= sc;
      drive   <= drive_c;
      spin_on <= spin_c;
    end
  end

endmodule

[rtl/owm_speed.sv]
// owm_speed: stage 2, three-wheel kinematics in Q16 with optional spin.
// Depends on owm_pkg.
module owm_speed
  import owm_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  stick_t x,
  input  stick_t y,
  input  stick_t s,
  input  logic   drive_in,
  input  logic   spin_on,
  output speed_t a,
  output speed_t b,
  output speed_t c,
  output logic   drive
);

  localparam logic signed [16:0] K = 17'(SQRT3_HALF_Q16);

  speed_t xq, xh, sq, yk;
  speed_t a_c, b_c, c_c;
  logic signed [26:0] prod;

  always_comb begin
    xq   = speed_t'(x) <<< Q16_SHIFT;
    xh   = speed_t'(x) <<< HALF_SHIFT;
    sq   = spin_on ? (speed_t'(s) <<< Q16_SHIFT) : '0;
    prod = y * K;
    yk   = speed_t'(prod);
    a_c  = -xq - sq;
    b_c  = xh + yk - sq;
    c_c  = xh - yk - sq;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a     <= a_c;
      b     <= b_c;
      c     <= c_c;
      drive <= drive_in;
    end
  end

endmodule

[rtl/owm_wheel.sv]
// owm_wheel: stages 3 and 4 for one wheel, sign and cap, then duty map.
// Depends on owm_pkg.
module owm_wheel
  import owm_pkg::*;
(
  input  logic              clk,
  input  logic              en3,
  input  logic              en4,
  input  speed_t            speed,
  input  logic              drive_in,
  input  logic [DUTY_W-1:0] duty_base,
  output logic              dir,
  output logic [DUTY_W-1:0] duty
);

  localparam units_t CAP = 9'(STICK_LIMIT);

  speed_t      mag;
  logic [10:0] whole;
  units_t      units_c;
  logic        neg3, drive3;
  units_t      units3;

  always_comb begin
    mag     = speed[27] ? -speed : speed;
    whole   = mag[26:Q16_SHIFT];
    units_c = (whole > 11'(CAP)) ? CAP : whole[8:0];
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      neg3   <= speed[27];
      units3 <= units_c;
      drive3 <= drive_in;
    end
  end

  logic [16:0] prod;
  logic [6:0]  step;
  logic [8:0]  sum;

  always_comb begin
    prod = units3 * 8'(RECIP5);
    step = prod[16:RECIP5_SHIFT];
    sum  = {1'b0, duty_base} + {2'b0, step};
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      dir  <= drive3 & neg3;
      if (!drive3)
        duty <= '0;
      else if (sum > 9'(DUTY_MAX))
        duty <= 8'(DUTY_MAX);
      else
        duty <= sum[DUTY_W-1:0];
    end
  end

endmodule

[rtl/omni_wheel_mixer.sv]
// omni_wheel_mixer: top level of the three-wheel omni drive mixer.
// Depends on owm_pkg, owm_ifs, owm_cfg_regs, owm_centre, owm_speed, owm_wheel.
//
// Turns three radio pulse widths (x, y, spin) into direction and PWM duty for
// the three wheels of an omni base. Four register stages: centre/clamp and
// deadband tests, Q16 kinematics (one 10x17 multiply), abs and cap per wheel,
// then the divide-by-five duty map (reciprocal multiply) into the output
// register. One item per cycle sustained while the result channel is ready.
// Each stage holds a valid bit and loads when it is empty or its successor
// loads, so bubbles collapse and a stall at the result channel holds every
// occupied stage; cmd.ready follows that chain from mix.ready. Registers are
// written through cfg, which is always ready; write them only while no item is
// in flight.
module omni_wheel_mixer
  import owm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  owm_cmd_if.sink   cmd,
  owm_mix_if.source mix,
  owm_cfg_if.sink   cfg
);

  cfg_t regs;

  owm_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // stage valid bits and load enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4       = !v4 || mix.ready;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign cmd.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= cmd.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1: centre, clamp, deadbands
  stick_t x1, y1, s1;
  logic   drive1, spin1;

  owm_centre u_centre (
    .clk        (clk),
    .en         (en1),
    .x_pulse    (cmd.x_pulse),
    .y_pulse    (cmd.y_pulse),
    .spin_pulse (cmd.spin_pulse),
    .regs       (regs),
    .x          (x1),
    .y          (y1),
    .s          (s1),
    .drive      (drive1),
    .spin_on    (spin1)
  );

  // stage 2: wheel speeds
  speed_t a2, b2, c2;
  logic   drive2;

  owm_speed u_speed (
    .clk      (clk),
    .en       (en2),
    .x        (x1),
    .y        (y1),
    .s        (s1),
    .drive_in (drive1),
    .spin_on  (spin1),
    .a        (a2),
    .b        (b2),
    .c        (c2),
    .drive    (drive2)
  );

  // stages 3 and 4: one unit per wheel
  owm_wheel u_wheel_a (
    .clk       (clk),
    .en3       (en3),
    .en4       (en4),
    .speed     (a2),
    .drive_in  (drive2),
    .duty_base (regs.duty_base),
    .dir       (mix.dir_a),
    .duty      (mix.duty_a)
  );

  owm_wheel u_wheel_b (
    .clk       (clk),
    .en3       (en3),
    .en4       (en4),
    .speed     (b2),
    .drive_in  (drive2),
    .duty_base (regs.duty_base),
    .dir       (mix.dir_b),
    .duty      (mix.duty_b)
  );

  owm_wheel u_wheel_c (
    .clk       (clk),
    .en3       (en3),
    .en4       (en4),
    .speed     (c2),
    .drive_in  (drive2),
    .duty_base (regs.duty_base),
    .dir       (mix.dir_c),
    .duty      (mix.duty_c)
  );

  // drive flag follows the wheel stages
  logic drive3, drive4;

  always_ff @(posedge clk) begin
    if (en3) drive3 <= drive2;
    if (en4) drive4 <= drive3;
  end

  assign mix.drive_on = drive4;
  assign mix.valid    = v4;

`ifndef ASSERT_OFF
  // a stopped result carries no direction and no duty
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    mix.valid && !mix.drive_on |->
      !mix.dir_a && !mix.dir_b && !mix.dir_c &&
      mix.duty_a == '0 && mix.duty_b == '0 && mix.duty_c == '0)
    else $error("stopped result with nonzero wheel output");

  // a driven wheel never runs below the zero-speed duty
  a_duty_floor: assert property (@(posedge clk) disable iff (rst)
    mix.valid && mix.drive_on |->
      mix.duty_a >= regs.duty_base && mix.duty_b >= regs.duty_base &&
      mix.duty_c >= regs.duty_base)
    else $error("driven duty below base");

  // an accepted item with a full pipe and stalled output cannot happen
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && v3 && v4 && !mix.ready |-> !cmd.ready)
    else $error("item accepted into a stalled full pipeline");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !mix.valid)
    else $error("result valid right after reset");
`endif

endmodule

[tb/owm_mix_checker.sv]
`timescale 1ns / 100ps
// owm_mix_checker: passive scoreboard for omni_wheel_mixer.
// Watches the cmd, mix and cfg channels; depends on owm_pkg and owm_ifs.
module owm_mix_checker
  import owm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  owm_cmd_if   cmd,
  owm_mix_if   mix,
  owm_cfg_if   cfg,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic              drive_on;
    logic              dir_a;
    logic              dir_b;
    logic              dir_c;
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
  } wheel_set_t;

  localparam longint Q16       = 64'd1 << Q16_SHIFT;
  localparam longint HALF_Q16  = Q16 / 2;
  localparam longint SPEED_CAP = STICK_LIMIT * Q16;
  localparam longint DUTY_STEP = 5 * Q16;

  cfg_t       regs;
  wheel_set_t wheel_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int centre_stick(logic [PULSE_W-1:0] p);
    int v;
    v = int'(p) - int'(regs.neutral_width);
    if (v < -STICK_LIMIT) v = -STICK_LIMIT;
    if (v > STICK_LIMIT) v = STICK_LIMIT;
    return v;
  endfunction

  function automatic int abs_int(int v);
    return (v < 0) ? -v : v;
  endfunction

  // sign -> direction, capped magnitude -> base + trunc(mag / 5)
  function automatic void map_wheel(longint speed, output logic dir,
                                    output logic [DUTY_W-1:0] duty);
    longint mag;
    longint d;
    dir = (speed < 0);
    mag = dir ? -speed : speed;
    if (mag > SPEED_CAP) mag = SPEED_CAP;
    d = longint'(regs.duty_base) + mag / DUTY_STEP;
    if (d > DUTY_MAX) d = DUTY_MAX;
    duty = d[DUTY_W-1:0];
  endfunction

  function automatic wheel_set_t mix_wheels(logic [PULSE_W-1:0] x_p, logic [PULSE_W-1:0] y_p,
                                            logic [PULSE_W-1:0] s_p);
    int         x, y, s;
    longint     a, b, c;
    wheel_set_t r;
    x = centre_stick(x_p);
    y = centre_stick(y_p);
    s = centre_stick(s_p);
    r = '0;
    if (abs_int(x) <= int'(regs.stick_deadband) && abs_int(y) <= int'(regs.stick_deadband) &&
        abs_int(s) <= int'(regs.stick_deadband))
      return r;
    a = -longint'(x) * Q16;
    b = longint'(x) * HALF_Q16 + longint'(y) * SQRT3_HALF_Q16;
    c = longint'(x) * HALF_Q16 - longint'(y) * SQRT3_HALF_Q16;
    if (abs_int(s) > int'(regs.spin_deadband)) begin
      a -= longint'(s) * Q16;
      b -= longint'(s) * Q16;
      c -= longint'(s) * Q16;
    end
    r.drive_on = 1'b1;
    map_wheel(a, r.dir_a, r.duty_a);
    map_wheel(b, r.dir_b, r.duty_b);
    map_wheel(c, r.dir_c, r.duty_c);
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    wheel_set_t want;
    if (rst) begin
      regs = '{NEUTRAL_RST, STICK_DB_RST, SPIN_DB_RST, DUTY_BASE_RST};
      wheel_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_NEUTRAL:   regs.neutral_width  = cfg.data[PULSE_W-1:0];
          REG_STICK_DB:  regs.stick_deadband = cfg.data[DB_W-1:0];
          REG_SPIN_DB:   regs.spin_deadband  = cfg.data[DB_W-1:0];
          REG_DUTY_BASE: regs.duty_base      = cfg.data[DUTY_W-1:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready)
        wheel_q.push_back(mix_wheels(cmd.x_pulse, cmd.y_pulse, cmd.spin_pulse));
      if (mix.valid && mix.ready) begin
        if (wheel_q.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual drive_on=%0b",
                   $time, mix.drive_on);
          fail_count++;
        end else begin
          want = wheel_q.pop_front();
          check_field("drive_on", want.drive_on, mix.drive_on);
          check_field("dir_a", want.dir_a, mix.dir_a);
          check_field("dir_b", want.dir_b, mix.dir_b);
          check_field("dir_c", want.dir_c, mix.dir_c);
          check_field("duty_a", want.duty_a, mix.duty_a);
          check_field("duty_b", want.duty_b, mix.duty_b);
          check_field("duty_c", want.duty_c, mix.duty_c);
        end
      end
    end
    pending = wheel_q.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// tb: stimulus and verdict for omni_wheel_mixer.
// Depends on owm_pkg, owm_ifs, the mixer RTL and owm_mix_checker.
module tb;
  import owm_pkg::*;

  localparam int HOLD_CYCLES  = 120;   // long receiver hold, fills the 4-stage pipe
  localparam int QUIET_LIMIT  = 3000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 8;     // pipe is 4 deep; a little margin on top

  // {x, y, spin}; neutral 1500, stick deadband 50, spin deadband 25 after reset
  localparam logic [3*PULSE_W-1:0] DIRECTED [20] = '{
    {12'd1500, 12'd1500, 12'd1500},  // centered: stop
    {12'd1550, 12'd1450, 12'd1525},  // every stick right on the deadband: stop
    {12'd1551, 12'd1500, 12'd1500},  // x one past the deadband
    {12'd1500, 12'd1449, 12'd1500},  // y one past, negative
    {12'd1500, 12'd1500, 12'd1551},  // spin alone wakes the drive
    {12'd0,    12'd0,    12'd0},     // all at the bottom rail
    {12'd4095, 12'd4095, 12'd4095},  // all at the top rail
    {12'd0,    12'd4095, 12'd1500},
    {12'd4095, 12'd0,    12'd1500},
    {12'd1500, 12'd4095, 12'd1500},  // pure forward
    {12'd1500, 12'd0,    12'd1500},  // pure reverse
    {12'd2000, 12'd1500, 12'd1525},  // spin on its deadband: not mixed
    {12'd2000, 12'd1500, 12'd1526},  // spin one past: mixed in
    {12'd1600, 12'd1500, 12'd1400},  // wheel A lands on exactly zero
    {12'd1700, 12'd1500, 12'd1600},  // wheels B and C land on exactly zero
    {12'd2047, 12'd2048, 12'd2047},
    {12'd2048, 12'd2047, 12'd2048},
    {12'd1500, 12'd1500, 12'd0},     // full negative spin only
    {12'd1000, 12'd2000, 12'd1000},  // mixing pushes past the 500 cap
    {12'd2001, 12'd1500, 12'd1500}   // x clamps at 500
  };

  logic clk;
  logic rst;
  int   fails;
  int   pending;

  // knobs shared between the stimulus and the receiver process
  int gap_pct;        // chance of a sender gap after an item
  int stall_pct;      // chance per cycle of a receiver stall burst
  bit no_idle;        // final stretch: both sides run flat out
  int hold_requests;  // bumped by the stimulus to ask for one long hold
  int hold_served;
  bit long_hold;      // sender keeps pushing while this is set
  int stall_left;
  int idle_cycles;
  int cur_neutral;    // current settings, used to aim the random sticks
  int cur_stick_db;

  owm_cmd_if cmd_ch ();
  owm_mix_if mix_ch ();
  owm_cfg_if cfg_ch ();

  omni_wheel_mixer uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .mix (mix_ch),
    .cfg (cfg_ch)
  );

  owm_mix_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .mix        (mix_ch),
    .cfg        (cfg_ch),
    .fail_count (fails),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (mix_ch.valid && mix_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall bursts plus the long hold on request. The hold
  // is counted here so the sender never waits on it.
  initial begin
    mix_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        mix_ch.ready <= 1'b0;
      end else begin
        if (hold_served != hold_requests) begin
          hold_served = hold_requests;
          stall_left  = HOLD_CYCLES;
          long_hold   = 1'b1;
        end
        if (stall_left > 0) begin
          stall_left--;
          mix_ch.ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < stall_pct) begin
          stall_left = $urandom_range(1, 15) - 1;
          long_hold  = 1'b0;
          mix_ch.ready <= 1'b0;
        end else begin
          long_hold = 1'b0;
          mix_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Offer one item and hold it until accepted; maybe leave a gap after it.
  // Called at a rising edge, returns at one.
  task automatic send_item(input logic [PULSE_W-1:0] x, input logic [PULSE_W-1:0] y,
                           input logic [PULSE_W-1:0] s);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.x_pulse    <= x;
    cmd_ch.y_pulse    <= y;
    cmd_ch.spin_pulse <= s;
    do @(posedge clk); while (!cmd_ch.ready);
    if (!no_idle && !long_hold && $urandom_range(0, 99) < gap_pct) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Stick pulse aimed around the current neutral. Most land in the live
  // range, some hug the deadband edge, a few are anywhere on the 12-bit scale.
  function automatic logic [PULSE_W-1:0] rand_pulse(bit near_edge);
    int v;
    int w;
    int sel;
    w   = cur_stick_db + 3;
    sel = near_edge ? 1 : $urandom_range(0, 9);
    case (sel)
      0:       v = $urandom_range(0, 4095);
      1:       v = cur_neutral + int'($urandom_range(0, 2 * w)) - w;
      2:       v = cur_neutral;
      default: v = cur_neutral + int'($urandom_range(0, 1200)) - 600;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[PULSE_W-1:0];
  endfunction

  // n random items; the long hold is asked for at item hold_at (none if < 0)
  task automatic run_random(input int n, input int hold_at);
    bit edge_item;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_requests++;
      // roughly one in eight has all three sticks near center -> stop cases
      edge_item = ($urandom_range(0, 7) == 0);
      send_item(rand_pulse(edge_item), rand_pulse(edge_item), rand_pulse(edge_item));
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Write all four registers back to back. Bits above a register's width
  // carry junk; the block must ignore them.
  task automatic load_config(input int neutral, input int stick_db, input int spin_db,
                             input int base);
    logic [CFG_DATA_W-1:0] raw;
    write_reg(REG_NEUTRAL, neutral[CFG_DATA_W-1:0]);
    raw = CFG_DATA_W'($urandom_range(0, 4095));
    raw[DB_W-1:0] = stick_db[DB_W-1:0];
    write_reg(REG_STICK_DB, raw);
    raw = CFG_DATA_W'($urandom_range(0, 4095));
    raw[DB_W-1:0] = spin_db[DB_W-1:0];
    write_reg(REG_SPIN_DB, raw);
    raw = CFG_DATA_W'($urandom_range(0, 4095));
    raw[DUTY_W-1:0] = base[DUTY_W-1:0];
    write_reg(REG_DUTY_BASE, raw);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    cur_neutral  = neutral;
    cur_stick_db = stick_db;
  endtask

  task automatic random_config();
    load_config($urandom_range(1000, 2000), $urandom_range(0, 120), $urandom_range(0, 120),
                $urandom_range(0, 255));
  endtask

  // Stop offering, wait for every expected result, then let the pipe settle.
  // pending is sampled on the falling edge, away from the checker's update.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst               <= 1'b1;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.x_pulse    <= '0;
    cmd_ch.y_pulse    <= '0;
    cmd_ch.spin_pulse <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_NEUTRAL;
    cfg_ch.data       <= '0;
    gap_pct       = 15;
    stall_pct     = 15;
    no_idle       = 1'b0;
    hold_requests = 0;
    hold_served   = 0;
    long_hold     = 1'b0;
    stall_left    = 0;
    cur_neutral   = 1500;
    cur_stick_db  = 50;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners on the reset settings
    for (int i = 0; i < 20; i++)
      send_item(DIRECTED[i][3*PULSE_W-1:2*PULSE_W], DIRECTED[i][2*PULSE_W-1:PULSE_W],
                DIRECTED[i][PULSE_W-1:0]);
    drain();

    // zero deadbands and zero base; long hold early on to back up the input
    gap_pct   = 20;
    stall_pct = 20;
    load_config(1500, 0, 0, 0);
    run_random(190, 40);
    drain();

    // deadbands above 500: every item must stop
    load_config(4095, 511, 511, 255);
    run_random(25, -1);
    drain();

    // neutral at zero, so every stick reads 0..500; base over 155 overflows
    load_config(0, 499, 500, 200);
    run_random(25, -1);
    drain();

    // top base: duty saturation on most driven wheels
    gap_pct   = 5;
    stall_pct = 30;
    load_config(2048, 10, 0, 255);
    run_random(180, -1);
    drain();

    gap_pct   = 10;
    stall_pct = 10;
    random_config();
    run_random(170, -1);
    drain();

    gap_pct   = 30;
    stall_pct = 5;
    random_config();
    run_random(170, -1);
    drain();

    // last stretch at full rate on both sides
    no_idle = 1'b1;
    random_config();
    run_random(170, -1);
    drain();

    if (fails == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
